// ===== hdl/hrlp_pkg.sv =====
// Package for the hex record line parser: constants, payload types and helpers.
`default_nettype none

package hrlp_pkg;

    // Page buffer size in bytes and data bytes carried by one record line
    localparam int PAGE_BYTES        = 256;
    localparam int RECORD_DATA_BYTES = 16;

    // Width of a page address
    localparam int PAGE_AW = $clog2(PAGE_BYTES);

    // Character positions counted from the colon
    localparam int POS_TYPE_FIRST  = 7;
    localparam int POS_TYPE_SECOND = 8;
    localparam int POS_DATA_FIRST  = 9;
    localparam int POS_DATA_END    = POS_DATA_FIRST + 2 * RECORD_DATA_BYTES;
    localparam int POS_LAST        = 8 + 2 * RECORD_DATA_BYTES + 4;
    localparam int POS_W           = $clog2(POS_LAST + 1);

    // Character codes
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    typedef enum logic [0:0] {
        EVENT_DATA  = 1'b0,
        EVENT_START = 1'b1
    } event_kind_t;

    typedef struct packed {
        logic [7:0] rx_char;
        logic [7:0] line_base;
    } hrlp_in_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [7:0]  write_address;
        logic [7:0]  data_byte;
    } hrlp_out_t;

    // Table of base offset modulo page size, built at elaboration
    typedef logic [PAGE_AW-1:0] base_wrap_t [256];

    function automatic base_wrap_t base_wrap_table();
        base_wrap_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = PAGE_AW'(i % PAGE_BYTES);
        end
        return t;
    endfunction

    localparam base_wrap_t BASE_WRAP = base_wrap_table();

    // ASCII hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            v = c - CHAR_UP_A + 8'd10;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            v = c - CHAR_LO_A + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hex_record_line_parser_core.sv =====
// Hex record line parser: character stream in, page byte writes and start events out.
// A result appears registered on the m_ side in the cycle after the transfer of the character
// that completes it. Throughput: one character per cycle, limited only by the single
// output register; a new character is taken while a result waits if m_ready is high.
// Reset (aresetn low, synchronous): parser goes idle awaiting ':', output empties,
// latched base, nibble and type flag clear to zero.
`default_nettype none

module hex_record_line_parser_core
    import hrlp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,

    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire hrlp_in_t  s_payload,

    output logic           m_valid,
    input  wire logic      m_ready,
    output hrlp_out_t      m_payload
);

    // Parser state: position since the colon (zero while idle), the nibble held
    // from the first data character of a pair, the type flag and the running
    // page address of the next data byte.
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [3:0]         high_nib_reg,  high_nib_next;
    logic               type_zero_reg, type_zero_next;
    logic [PAGE_AW-1:0] addr_reg,      addr_next;

    // Output register
    logic               m_valid_reg,   m_valid_next;
    hrlp_out_t          m_data_reg,    m_data_next;

    logic               s_xfer;
    logic               emit;
    hrlp_out_t          result;
    logic [3:0]         nib;
    logic [PAGE_AW+7:0] addr_ext;

    // Take a new character whenever the output is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    assign nib      = hex_nibble(s_payload.rx_char);
    assign addr_ext = {8'h00, addr_reg};

    // Single-pass step of the parser on the character at the input
    always_comb begin
        pos_next       = pos_reg;
        high_nib_next  = high_nib_reg;
        type_zero_next = type_zero_reg;
        addr_next      = addr_reg;
        emit           = 1'b0;
        result         = '{event_kind: EVENT_DATA, write_address: 8'h00, data_byte: 8'h00};

        if (pos_reg == '0) begin
            // Idle: drop everything but the colon, which latches the page base
            if (s_payload.rx_char == CHAR_COLON) begin
                addr_next = BASE_WRAP[s_payload.line_base];
                pos_next  = POS_W'(1);
            end
        end else begin
            if (pos_reg >= POS_W'(POS_LAST)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end

            if (pos_reg == POS_W'(POS_TYPE_FIRST)) begin
                type_zero_next = (s_payload.rx_char == CHAR_ZERO);
            end else if (pos_reg == POS_W'(POS_TYPE_SECOND)) begin
                // End record: signal start of application and go idle
                if (type_zero_reg && s_payload.rx_char == CHAR_ONE) begin
                    emit              = 1'b1;
                    result.event_kind = EVENT_START;
                    pos_next          = '0;
                end
            end else if (pos_reg >= POS_W'(POS_DATA_FIRST) &&
                         pos_reg <  POS_W'(POS_DATA_END)) begin
                // Data starts at an odd position: odd holds the high nibble,
                // even completes the byte and advances the page address
                if (pos_reg[0]) begin
                    high_nib_next = nib;
                end else begin
                    emit                 = 1'b1;
                    result.event_kind    = EVENT_DATA;
                    result.write_address = addr_ext[7:0];
                    result.data_byte     = {high_nib_reg, nib};
                    if (addr_reg == PAGE_AW'(PAGE_BYTES - 1)) begin
                        addr_next = '0;
                    end else begin
                        addr_next = addr_reg + PAGE_AW'(1);
                    end
                end
            end
        end
    end

    // Output register: load on a producing transfer, clear when drained
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_xfer && emit) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            high_nib_reg  <= '0;
            type_zero_reg <= 1'b0;
            addr_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Advance the parser only on an input transfer
            if (s_xfer) begin
                pos_reg       <= pos_next;
                high_nib_reg  <= high_nib_next;
                type_zero_reg <= type_zero_next;
                addr_reg      <= addr_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the hex record line parser core.

module tb_top;
    import hrlp_pkg::*;

    typedef enum logic {
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

    // One directed character: payload plus, where obvious, the result it must produce
    typedef struct {
        logic [7:0] rx_char;
        logic [7:0] line_base;
        row_kind_t  kind;
        hrlp_out_t  want;
    } stim_row_t;

    localparam hrlp_out_t  NO_RESULT    = '0;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam int         RANDOM_CHARS = 1100;
    localparam int         MAX_WAIT     = 12;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         DATA_CHARS   = 2 * RECORD_DATA_BYTES;
    // data characters, two checksum characters and the line end
    localparam int         LINE_TAIL    = DATA_CHARS + 4;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    hrlp_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    hrlp_out_t m_payload;

    // Parser state as the testbench tracks it
    int         char_index     = 0;
    logic [3:0] nib_hi         = 4'h0;
    bit         type_lead_zero = 1'b0;
    logic [7:0] page_base      = 8'h00;

    hrlp_out_t  pending_events[$];

    int  error_count   = 0;
    int  chars_fed     = 0;
    int  chars_parsed  = 0;
    int  writes_seen   = 0;
    int  starts_seen   = 0;
    bit  send_calm     = 1'b0;
    bit  recv_calm     = 1'b0;

    string hex_digits = "0123456789ABCDEFabcdef";

    // Directed part: idle noise, an end record, then a type "11" data line at base 0xFE
    // so that the third byte wraps to address 0; the third byte also carries a colon
    // inside the line and a non-hex digit.
    stim_row_t directed_rows [0:25] = '{
        '{8'h00,      8'h00, ROW_PREDICT, NO_RESULT},
        '{8'hFF,      8'hFF, ROW_PREDICT, NO_RESULT},
        '{CHAR_COLON, 8'h00, ROW_PREDICT, NO_RESULT},
        '{"0",        8'hFF, ROW_PREDICT, NO_RESULT},
        '{"0",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"0",        8'hFF, ROW_PREDICT, NO_RESULT},
        '{"0",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"0",        8'hFF, ROW_PREDICT, NO_RESULT},
        '{"0",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"0",        8'hFF, ROW_PREDICT, NO_RESULT},
        '{"1",        8'hA5, ROW_TYPED,   hrlp_out_t'{EVENT_START, 8'h00, 8'h00}},
        '{CHAR_COLON, 8'hFE, ROW_PREDICT, NO_RESULT},
        '{"1",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"0",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"F",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"F",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"F",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"F",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"1",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"1",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"F",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"f",        8'h00, ROW_TYPED,   hrlp_out_t'{EVENT_DATA, 8'hFE, 8'hFF}},
        '{"a",        8'h00, ROW_PREDICT, NO_RESULT},
        '{"0",        8'h00, ROW_TYPED,   hrlp_out_t'{EVENT_DATA, 8'hFF, 8'hA0}},
        '{CHAR_COLON, 8'h33, ROW_PREDICT, NO_RESULT},
        '{"G",        8'h00, ROW_TYPED,   hrlp_out_t'{EVENT_DATA, 8'h00, 8'h00}}
    };

    hex_record_line_parser_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #2 aclk = ~aclk;

    // Hard stop in case a handshake never completes
    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Draw a per-transfer wait; now and then toggle into or out of a burst with no waits
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] hex_char();
        return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
    endfunction

    // Mostly hex digits, with an occasional arbitrary code to hit the zero-nibble path
    function automatic logic [7:0] line_char();
        return ($urandom_range(0, 15) == 0) ? rand_byte() : hex_char();
    endfunction

    // Line base is only sampled at a colon; randomize it everywhere else to prove that
    function automatic hrlp_in_t noisy_base(input logic [7:0] c);
        return '{rx_char: c, line_base: rand_byte()};
    endfunction

    // Digits map through their low nibble; letters A-F and a-f share low nibbles 1..6
    function automatic logic [3:0] decode_hex_digit(input logic [7:0] c);
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            return c[3:0];
        end
        if (c inside {[CHAR_UP_A:CHAR_UP_F], [CHAR_LO_A:CHAR_LO_F]}) begin
            return c[3:0] + 4'd9;
        end
        return 4'h0;
    endfunction

    // Advance the tracked parser by one character; flag whether it was consumed
    // (not dropped while idle) and whether it completes a result.
    function automatic void predict_char(input hrlp_in_t it, output bit taken,
                                         output bit emit, output hrlp_out_t res);
        int slot;
        int step;
        taken = 1'b1;
        emit  = 1'b0;
        res   = NO_RESULT;
        if (char_index == 0) begin
            taken = (it.rx_char == CHAR_COLON);
            if (taken) begin
                page_base  = it.line_base;
                char_index = 1;
            end
            return;
        end
        step = char_index;
        if (step == POS_TYPE_FIRST) begin
            type_lead_zero = (it.rx_char == CHAR_ZERO);
        end else if (step == POS_TYPE_SECOND) begin
            // End record: raise the start event and drop back to idle at once
            if (type_lead_zero && it.rx_char == CHAR_ONE) begin
                emit             = 1'b1;
                res.event_kind   = EVENT_START;
                char_index       = 0;
                return;
            end
        end else if (step >= POS_DATA_FIRST && step < POS_DATA_END) begin
            if (((step - POS_DATA_FIRST) % 2) == 0) begin
                nib_hi = decode_hex_digit(it.rx_char);
            end else begin
                slot              = (step - POS_DATA_FIRST) / 2;
                emit              = 1'b1;
                res.event_kind    = EVENT_DATA;
                res.write_address = 8'((int'(page_base) + slot) % PAGE_BYTES);
                res.data_byte     = {nib_hi, decode_hex_digit(it.rx_char)};
            end
        end
        char_index = (step >= POS_LAST) ? 0 : step + 1;
    endfunction

    // Present one character, hold it until the transfer, then queue what it must produce.
    // A typed expectation replaces the predicted one for that character.
    task automatic send_char(input hrlp_in_t it, input bit typed, input hrlp_out_t want);
        int        gap;
        bit        taken;
        bit        emit;
        hrlp_out_t res;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        predict_char(it, taken, emit, res);
        chars_fed++;
        if (taken) begin
            chars_parsed++;
        end
        if (typed) begin
            pending_events.push_back(want);
        end else if (emit) begin
            pending_events.push_back(res);
        end
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
    endtask

    // Result side: stall a random number of cycles per transfer, with calm stretches
    initial begin : result_sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare every result transfer against the oldest queued expectation
    always @(posedge aclk) begin : check_results
        hrlp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d addr=%02h data=%02h",
                                          m_payload.event_kind, m_payload.write_address,
                                          m_payload.data_byte));
            end else begin
                want = pending_events.pop_front();
                if (m_payload.event_kind != want.event_kind) begin
                    report_mismatch($sformatf("event_kind got %0d want %0d",
                                              m_payload.event_kind, want.event_kind));
                end
                if (m_payload.write_address != want.write_address) begin
                    report_mismatch($sformatf("write_address got %02h want %02h",
                                              m_payload.write_address, want.write_address));
                end
                if (m_payload.data_byte != want.data_byte) begin
                    report_mismatch($sformatf("data_byte got %02h want %02h",
                                              m_payload.data_byte, want.data_byte));
                end
            end
            if (m_payload.event_kind == EVENT_START) begin
                starts_seen++;
            end else begin
                writes_seen++;
            end
        end
    end

    initial begin : stimulus
        hrlp_in_t   item;
        logic [7:0] base;
        logic [7:0] c;
        int         pick;
        int         span;
        int         parsed_goal;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i]) begin
            item = '{rx_char: directed_rows[i].rx_char, line_base: directed_rows[i].line_base};
            send_char(item, directed_rows[i].kind == ROW_TYPED, directed_rows[i].want);
        end
        hold_until_drained();

        // Random part: mostly well-formed lines with random content, plus end records,
        // idle noise and lines cut short so the parser falls out of step.
        parsed_goal = chars_parsed + RANDOM_CHARS;
        while (chars_parsed < parsed_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) send_char(noisy_base(rand_byte()), 1'b0, NO_RESULT);
            end else begin
                // Bias the latched base toward the extremes
                base = ($urandom_range(0, 7) == 0) ? 8'h00 :
                       (($urandom_range(0, 7) == 0) ? 8'hFF : rand_byte());
                item = '{rx_char: CHAR_COLON, line_base: base};
                send_char(item, 1'b0, NO_RESULT);
                repeat (6) send_char(noisy_base(hex_char()), 1'b0, NO_RESULT);
                if (pick < 22) begin
                    send_char(noisy_base(CHAR_ZERO), 1'b0, NO_RESULT);
                    send_char(noisy_base(CHAR_ONE), 1'b0, NO_RESULT);
                end else begin
                    if (pick < 70) begin
                        repeat (2) send_char(noisy_base(CHAR_ZERO), 1'b0, NO_RESULT);
                    end else begin
                        repeat (2) send_char(noisy_base(hex_char()), 1'b0, NO_RESULT);
                    end
                    span = (pick >= 92) ? $urandom_range(0, LINE_TAIL - 1) : LINE_TAIL;
                    for (int k = 0; k < span; k++) begin
                        if (k < DATA_CHARS) begin
                            c = line_char();
                        end else if (k < DATA_CHARS + 2) begin
                            c = hex_char();
                        end else if (k == DATA_CHARS + 2) begin
                            c = CHAR_CR;
                        end else begin
                            c = CHAR_LF;
                        end
                        send_char(noisy_base(c), 1'b0, NO_RESULT);
                    end
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Fed %0d characters, %0d taken by the parser outside idle drops.",
                 chars_fed, chars_parsed);
        $display("Checked %0d page byte writes and %0d start events, %0d mismatches.",
                 writes_seen, starts_seen, error_count);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== hex_record_line_parser_core.f =====
hdl/hrlp_pkg.sv
hdl/hex_record_line_parser_core.sv
tb/sv/tb_top.sv
